[rtl/trpe_pkg.sv]
package trpe_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned SIZE_W  = 12;
    localparam int unsigned RANGE_W = 16;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DATA_W  = 16;

    // scaling product and divider sizing
    localparam int unsigned PROD_W  = COORD_W + SIZE_W;
    localparam int unsigned CNT_W   = 5;

    // report layout
    localparam logic [POS_W-1:0] POS_ID     = 4'd0;
    localparam logic [POS_W-1:0] POS_TIP    = 4'd1;
    localparam logic [POS_W-1:0] POS_X_LO   = 4'd2;
    localparam logic [POS_W-1:0] POS_X_HI   = 4'd3;
    localparam logic [POS_W-1:0] POS_Y_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_Y_HI   = 4'd5;
    localparam logic [POS_W-1:0] POS_MAX    = 4'd15;

    // pen event codes
    localparam logic [KIND_W-1:0] PEN_UP   = 2'd0;
    localparam logic [KIND_W-1:0] PEN_DOWN = 2'd1;
    localparam logic [KIND_W-1:0] PEN_DRAG = 2'd2;

    localparam logic [COORD_W-1:0] COORD_MAX = 16'hFFFF;

    // register indexes
    localparam logic [IDX_W-1:0] REG_REPORT_ID = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_W  = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_RANGE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCREEN_H  = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_RANGE   = 3'd4;

    // register reset values
    localparam logic [BYTE_W-1:0]  RST_REPORT_ID = 8'd4;
    localparam logic [SIZE_W-1:0]  RST_SCREEN_W  = 12'd720;
    localparam logic [RANGE_W-1:0] RST_X_RANGE   = 16'd16384;
    localparam logic [SIZE_W-1:0]  RST_SCREEN_H  = 12'd576;
    localparam logic [RANGE_W-1:0] RST_Y_RANGE   = 16'd9600;

    typedef struct packed {
        logic [BYTE_W-1:0] report_byte;
        logic              last_byte;
    } rpt_t;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               mergeable;
    } evt_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV
    } scale_state_t;

    typedef enum logic [1:0] {
        TS_COLLECT,
        TS_SCALE_X,
        TS_SCALE_Y,
        TS_EMIT
    } top_state_t;

endpackage

[rtl/trpe_scale.sv]
module trpe_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [trpe_pkg::COORD_W-1:0]  raw,
    input  logic [trpe_pkg::SIZE_W-1:0]   size,
    input  logic [trpe_pkg::RANGE_W-1:0]  range,
    output logic                          done,
    output logic [trpe_pkg::COORD_W-1:0]  result
);

    trpe_pkg::scale_state_t state_reg, state_next;

    logic [trpe_pkg::COORD_W-1:0] raw_reg;
    logic [trpe_pkg::SIZE_W-1:0]  size_reg;
    logic [trpe_pkg::RANGE_W-1:0] range_reg;
    logic [trpe_pkg::PROD_W-1:0]  quo_reg, quo_next;
    logic [trpe_pkg::RANGE_W-1:0] rem_reg, rem_next;
    logic [trpe_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [trpe_pkg::COORD_W-1:0] result_reg, result_next;

    logic [trpe_pkg::RANGE_W:0]   rem_shift;
    logic                         fits;
    logic                         last_step;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trpe_pkg::SC_IDLE:
            begin
                if (start)
                begin
                    state_next = trpe_pkg::SC_MUL;
                end
            end
            trpe_pkg::SC_MUL:
            begin
                state_next = trpe_pkg::SC_DIV;
            end
            trpe_pkg::SC_DIV:
            begin
                if (last_step)
                begin
                    state_next = trpe_pkg::SC_IDLE;
                end
            end
            default:
            begin
                state_next = trpe_pkg::SC_IDLE;
            end
        endcase
    end

    // one restoring divide step per cycle
    assign rem_shift = {rem_reg, quo_reg[trpe_pkg::PROD_W-1]};
    assign fits      = rem_shift >= {1'b0, range_reg};
    assign last_step = cnt_reg == trpe_pkg::CNT_W'(trpe_pkg::PROD_W - 1);

    // datapath and outputs
    always_comb
    begin
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            trpe_pkg::SC_MUL:
            begin
                quo_next = trpe_pkg::PROD_W'(raw_reg) * trpe_pkg::PROD_W'(size_reg);
                rem_next = '0;
                cnt_next = '0;
            end
            trpe_pkg::SC_DIV:
            begin
                if (fits)
                begin
                    rem_next = trpe_pkg::RANGE_W'(rem_shift - {1'b0, range_reg});
                end
                else
                begin
                    rem_next = rem_shift[trpe_pkg::RANGE_W-1:0];
                end
                quo_next = {quo_reg[trpe_pkg::PROD_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    done_next = 1'b1;
                    // saturate on overflow or an unset range
                    if ((range_reg == '0) ||
                        (quo_next[trpe_pkg::PROD_W-1:trpe_pkg::COORD_W] != '0))
                    begin
                        result_next = trpe_pkg::COORD_MAX;
                    end
                    else
                    begin
                        result_next = quo_next[trpe_pkg::COORD_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // operand capture and datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == trpe_pkg::SC_IDLE) && start)
        begin
            raw_reg   <= raw;
            size_reg  <= size;
            range_reg <= range;
        end
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        result_reg <= result_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trpe_pkg::SC_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/touch_report_pen_events.sv]
// Touch report to pen event converter.
// Requests on the rpt channel carry one report byte each, with last_byte
// marking the end of a report. A report of six or more bytes whose first
// byte equals the configured id latches tip, X and Y (little-endian).
// X and Y are scaled one after the other in a shared multiply and
// bit-serial divide unit: a start, a multiply, one divide step per
// quotient bit, then the result. Non-final bytes and rejected reports
// never stall the rpt channel. A matching final byte stalls it through
// both scaling passes and the compare with the last event sent. A
// changed point or tip then puts one request on the evt channel, from
// a held output register. Bytes of the next report are taken while
// that event waits; a further matching report end holds in its compare
// cycle until the event is taken. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while idle,
// which the block itself does not enforce. Reset (rst_n low,
// asynchronous) restores the default register values, clears the byte
// position and forgets the last event (tip 0 at 0,0).
module touch_report_pen_events (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rpt_valid,
    output logic                          rpt_stall,
    input  trpe_pkg::rpt_t                rpt,
    output logic                          evt_valid,
    input  logic                          evt_stall,
    output trpe_pkg::evt_t                evt,
    input  logic                          cfg_we,
    input  logic [trpe_pkg::IDX_W-1:0]    cfg_index,
    input  logic [trpe_pkg::DATA_W-1:0]   cfg_data
);

    trpe_pkg::top_state_t state_reg, state_next;

    logic [trpe_pkg::BYTE_W-1:0]  report_id_reg;
    logic [trpe_pkg::SIZE_W-1:0]  screen_w_reg;
    logic [trpe_pkg::RANGE_W-1:0] x_range_reg;
    logic [trpe_pkg::SIZE_W-1:0]  screen_h_reg;
    logic [trpe_pkg::RANGE_W-1:0] y_range_reg;

    logic [trpe_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [trpe_pkg::BYTE_W-1:0]  seen_id_reg, seen_id_next;
    logic [trpe_pkg::BYTE_W-1:0]  staged_tip_reg, staged_tip_next;
    logic [trpe_pkg::COORD_W-1:0] staged_x_reg, staged_x_next;
    logic [trpe_pkg::COORD_W-1:0] staged_y_reg, staged_y_next;

    logic [trpe_pkg::BYTE_W-1:0]  touch_tip_reg;
    logic [trpe_pkg::COORD_W-1:0] touch_x_reg;
    logic [trpe_pkg::COORD_W-1:0] touch_y_reg;
    logic [trpe_pkg::COORD_W-1:0] px_reg;
    logic [trpe_pkg::COORD_W-1:0] py_reg;
    logic [trpe_pkg::BYTE_W-1:0]  prev_tip_reg;
    logic [trpe_pkg::COORD_W-1:0] prev_x_reg;
    logic [trpe_pkg::COORD_W-1:0] prev_y_reg;

    logic                         start_reg;
    logic                         evt_valid_reg;
    trpe_pkg::evt_t               evt_reg;

    logic                         rpt_take;
    logic                         report_ok;
    logic                         out_free;
    logic                         changed;
    logic                         scale_done;
    logic [trpe_pkg::COORD_W-1:0] scale_result;
    logic [trpe_pkg::COORD_W-1:0] scale_raw;
    logic [trpe_pkg::SIZE_W-1:0]  scale_size;
    logic [trpe_pkg::RANGE_W-1:0] scale_range;
    logic [trpe_pkg::KIND_W-1:0]  kind;

    assign rpt_take = rpt_valid && !rpt_stall;
    assign out_free = !evt_valid_reg || !evt_stall;

    // byte collection
    always_comb
    begin
        seen_id_next    = seen_id_reg;
        staged_tip_next = staged_tip_reg;
        staged_x_next   = staged_x_reg;
        staged_y_next   = staged_y_reg;
        pos_next        = pos_reg;
        if (rpt_take)
        begin
            case (pos_reg)
                trpe_pkg::POS_ID:   seen_id_next = rpt.report_byte;
                trpe_pkg::POS_TIP:  staged_tip_next = rpt.report_byte;
                trpe_pkg::POS_X_LO: staged_x_next = {staged_x_reg[15:8], rpt.report_byte};
                trpe_pkg::POS_X_HI: staged_x_next = {rpt.report_byte, staged_x_reg[7:0]};
                trpe_pkg::POS_Y_LO: staged_y_next = {staged_y_reg[15:8], rpt.report_byte};
                trpe_pkg::POS_Y_HI: staged_y_next = {rpt.report_byte, staged_y_reg[7:0]};
                default:
                begin
                end
            endcase
            if (rpt.last_byte)
            begin
                pos_next = '0;
            end
            else if (pos_reg != trpe_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    assign report_ok = rpt_take && rpt.last_byte && (pos_reg >= trpe_pkg::POS_Y_HI) &&
                       (seen_id_next == report_id_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trpe_pkg::TS_COLLECT:
            begin
                if (report_ok)
                begin
                    state_next = trpe_pkg::TS_SCALE_X;
                end
            end
            trpe_pkg::TS_SCALE_X:
            begin
                if (scale_done)
                begin
                    state_next = trpe_pkg::TS_SCALE_Y;
                end
            end
            trpe_pkg::TS_SCALE_Y:
            begin
                if (scale_done)
                begin
                    state_next = trpe_pkg::TS_EMIT;
                end
            end
            trpe_pkg::TS_EMIT:
            begin
                if (out_free)
                begin
                    state_next = trpe_pkg::TS_COLLECT;
                end
            end
            default:
            begin
                state_next = trpe_pkg::TS_COLLECT;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        rpt_stall = 1'b1;
        if (state_reg == trpe_pkg::TS_SCALE_Y)
        begin
            scale_raw   = touch_y_reg;
            scale_size  = screen_h_reg;
            scale_range = y_range_reg;
        end
        else
        begin
            scale_raw   = touch_x_reg;
            scale_size  = screen_w_reg;
            scale_range = x_range_reg;
        end
        if (state_reg == trpe_pkg::TS_COLLECT)
        begin
            rpt_stall = 1'b0;
        end
    end

    // shared scaling unit
    trpe_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .raw    (scale_raw),
        .size   (scale_size),
        .range  (scale_range),
        .done   (scale_done),
        .result (scale_result)
    );

    // event classification
    assign changed = (px_reg != prev_x_reg) || (py_reg != prev_y_reg) ||
                     (touch_tip_reg != prev_tip_reg);

    always_comb
    begin
        if (touch_tip_reg == '0)
        begin
            kind = trpe_pkg::PEN_UP;
        end
        else if (prev_tip_reg == '0)
        begin
            kind = trpe_pkg::PEN_DOWN;
        end
        else
        begin
            kind = trpe_pkg::PEN_DRAG;
        end
    end

    // payload of the output register and scaled coordinates
    always_ff @(posedge clk)
    begin
        if ((state_reg == trpe_pkg::TS_EMIT) && out_free && changed)
        begin
            evt_reg.event_kind <= kind;
            evt_reg.point_x    <= px_reg;
            evt_reg.point_y    <= py_reg;
            evt_reg.mergeable  <= kind == trpe_pkg::PEN_DRAG;
        end
        if ((state_reg == trpe_pkg::TS_SCALE_X) && scale_done)
        begin
            px_reg <= scale_result;
        end
        if ((state_reg == trpe_pkg::TS_SCALE_Y) && scale_done)
        begin
            py_reg <= scale_result;
        end
    end

    // control, configuration and report state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= trpe_pkg::TS_COLLECT;
            report_id_reg  <= trpe_pkg::RST_REPORT_ID;
            screen_w_reg   <= trpe_pkg::RST_SCREEN_W;
            x_range_reg    <= trpe_pkg::RST_X_RANGE;
            screen_h_reg   <= trpe_pkg::RST_SCREEN_H;
            y_range_reg    <= trpe_pkg::RST_Y_RANGE;
            pos_reg        <= '0;
            seen_id_reg    <= '0;
            staged_tip_reg <= '0;
            staged_x_reg   <= '0;
            staged_y_reg   <= '0;
            touch_tip_reg  <= '0;
            touch_x_reg    <= '0;
            touch_y_reg    <= '0;
            prev_tip_reg   <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            start_reg      <= 1'b0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            seen_id_reg    <= seen_id_next;
            staged_tip_reg <= staged_tip_next;
            staged_x_reg   <= staged_x_next;
            staged_y_reg   <= staged_y_next;

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    trpe_pkg::REG_REPORT_ID: report_id_reg <= cfg_data[trpe_pkg::BYTE_W-1:0];
                    trpe_pkg::REG_SCREEN_W:  screen_w_reg  <= cfg_data[trpe_pkg::SIZE_W-1:0];
                    trpe_pkg::REG_X_RANGE:   x_range_reg   <= cfg_data[trpe_pkg::RANGE_W-1:0];
                    trpe_pkg::REG_SCREEN_H:  screen_h_reg  <= cfg_data[trpe_pkg::SIZE_W-1:0];
                    trpe_pkg::REG_Y_RANGE:   y_range_reg   <= cfg_data[trpe_pkg::RANGE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // latch a matching report and kick off each scaling pass
            if (report_ok && (state_reg == trpe_pkg::TS_COLLECT))
            begin
                touch_tip_reg <= staged_tip_next;
                touch_x_reg   <= staged_x_next;
                touch_y_reg   <= staged_y_next;
            end
            start_reg <= (report_ok && (state_reg == trpe_pkg::TS_COLLECT)) ||
                         ((state_reg == trpe_pkg::TS_SCALE_X) && scale_done);

            // output register handshake
            if ((state_reg == trpe_pkg::TS_EMIT) && out_free && changed)
            begin
                evt_valid_reg <= 1'b1;
                prev_tip_reg  <= touch_tip_reg;
                prev_x_reg    <= px_reg;
                prev_y_reg    <= py_reg;
            end
            else if (evt_valid_reg && !evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

[rtl/trpe_checker.sv]
module trpe_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rpt_valid,
    input  logic                          rpt_stall,
    input  trpe_pkg::rpt_t                rpt,
    input  logic                          evt_valid,
    input  logic                          evt_stall,
    input  trpe_pkg::evt_t                evt
);

    // a stalled event holds
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("stalled event changed");

    // drag events and only drag events are mergeable
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt.mergeable == (evt.event_kind == trpe_pkg::PEN_DRAG)))
    else $error("mergeable flag disagrees with event kind");

    // no unused event code
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt.event_kind != 2'd3))
    else $error("event kind out of range");

    // a byte that does not end a report never blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_stall && !rpt.last_byte |=> !rpt_stall)
    else $error("stall after a mid-report byte");

    // a new event only follows a scaling pass
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_valid) |-> $past(rpt_stall))
    else $error("event raised without a scaling pass");

endmodule

bind touch_report_pen_events trpe_checker u_trpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
);
